// ===== sv/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the masked standard deviation block
// Item layouts, widths and register indexes used by the top level and its
// shared subtract unit.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_W      = 16;
  localparam int MEAN_W        = SAMPLE_W + FRACTION_BITS;
  localparam int DIVISOR_W     = 11;
  localparam int SQUARE_W      = 2 * MEAN_W;
  localparam int SUM_W         = 58;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int UNIT_W        = 32;
  localparam int CFG_DATA_W    = MEAN_W;
  localparam int CFG_INDEX_W   = 1;
  localparam int COUNT_W       = 6;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MEAN_VALUE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR    = 1'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                include_req;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  variance;
    logic [ROOT_W-1:0] std_dev;
  } out_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] diff;
    logic              ge;
  } sub_result_t;

endpackage

// ===== sv/msd_sub_unit.sv =====
// ----------------------------------------------------------------------------
// msd_sub_unit: shared compare and subtract unit
// Computes a - b and whether a >= b. The divider and the square root both
// take their steps through this one unit.
// ----------------------------------------------------------------------------
module msd_sub_unit (
  input  logic [msd_pkg::UNIT_W-1:0] a,
  input  logic [msd_pkg::UNIT_W-1:0] b,
  output msd_pkg::sub_result_t       result
);

  logic [msd_pkg::UNIT_W:0] wide;

  always_comb begin
    wide        = {1'b0, a} - {1'b0, b};
    result.diff = wide[msd_pkg::UNIT_W-1:0];
    // No borrow means a >= b.
    result.ge   = ~wide[msd_pkg::UNIT_W];
  end

endmodule

// ===== sv/masked_standard_deviation.sv =====
// ----------------------------------------------------------------------------
// masked_standard_deviation: population standard deviation in fixed point
// Accumulates saturated squared differences from a configured mean, then
// divides by a configured count and takes a truncated square root.
// ----------------------------------------------------------------------------
// Each input item carries a 16-bit sample, an include flag and a last flag.
// The sample is scaled to Q16.8, its absolute difference from mean_value is
// squared and, if included, added to a 58-bit accumulator that saturates at
// its maximum. An item that is not last produces no result and passes through
// acceptance, the 24x24 squaring multiplier and the saturating add before the
// next item can be accepted. A last item produces one result: after those
// steps come a 58-bit restoring division (one quotient bit per cycle) and a
// 29-bit digit-by-digit square root (one root bit per cycle), both stepping
// through the same shared compare and subtract unit, and then the output
// register is loaded. The accumulator is cleared once the division starts.
// in_stall stays high while an item is in progress. Results sit in an output
// register, so a stalled output only holds the block once a second result is
// ready. A divisor of zero gives a variance of all ones. Configuration writes
// are meant for idle periods; mean_value is Q16.8 and divisor is unsigned.
// ----------------------------------------------------------------------------
module masked_standard_deviation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [msd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  msd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output msd_pkg::out_item_t                  out_data
);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [msd_pkg::COUNT_W-1:0] DIV_LAST_STEP =
    msd_pkg::COUNT_W'(msd_pkg::SUM_W - 1);
  localparam logic [msd_pkg::COUNT_W-1:0] SQRT_LAST_STEP =
    msd_pkg::COUNT_W'(msd_pkg::ROOT_W - 1);

  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic [msd_pkg::MEAN_W-1:0]        mean_value;
  logic [msd_pkg::DIVISOR_W-1:0]     divisor;
  logic [msd_pkg::SAMPLE_W-1:0]      smp;
  logic                              inc;
  logic                              lst;
  logic [msd_pkg::SQUARE_W-1:0]      square;
  logic [msd_pkg::SUM_W-1:0]         sum;
  logic [msd_pkg::SUM_W-1:0]         sum_next;
  logic [msd_pkg::SUM_W-1:0]         work;
  logic [msd_pkg::SUM_W-1:0]         var_q;
  logic [msd_pkg::UNIT_W-1:0]        rem;
  logic [msd_pkg::ROOT_W-1:0]        root;
  logic [msd_pkg::COUNT_W-1:0]       cnt;

  logic                              in_accept;
  logic                              out_load;
  logic [msd_pkg::MEAN_W-1:0]        scaled;
  logic [msd_pkg::MEAN_W-1:0]        abs_diff;
  logic [msd_pkg::SUM_W:0]           sum_wide;
  logic [msd_pkg::DIVISOR_W:0]       div_shift;
  logic [msd_pkg::UNIT_W-1:0]        sqrt_shift;
  logic [msd_pkg::UNIT_W-1:0]        unit_a;
  logic [msd_pkg::UNIT_W-1:0]        unit_b;
  msd_pkg::sub_result_t              unit_res;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The output register takes a new result when it is empty or being drained.
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // Scaled sample and its absolute distance from the mean.
  always_comb begin
    scaled   = {smp, msd_pkg::FRACTION_BITS'(0)};
    abs_diff = (scaled >= mean_value) ? (scaled - mean_value) : (mean_value - scaled);
  end

  // Saturating accumulate of the registered square.
  always_comb begin
    sum_wide = {1'b0, sum} + (msd_pkg::SUM_W + 1)'(square);
    sum_next = sum_wide[msd_pkg::SUM_W] ? {msd_pkg::SUM_W{1'b1}}
                                        : sum_wide[msd_pkg::SUM_W-1:0];
  end

  // Operand selection for the shared unit. Division brings down one dividend
  // bit per step; the square root brings down two bits and tries root*4+1.
  always_comb begin
    div_shift  = {rem[msd_pkg::DIVISOR_W-1:0], work[msd_pkg::SUM_W-1]};
    sqrt_shift = {rem[msd_pkg::UNIT_W-3:0], work[msd_pkg::SUM_W-1 -: 2]};
    if (state == ST_DIV) begin
      unit_a = msd_pkg::UNIT_W'(div_shift);
      unit_b = msd_pkg::UNIT_W'(divisor);
    end else begin
      unit_a = sqrt_shift;
      unit_b = msd_pkg::UNIT_W'({root, 2'b01});
    end
  end

  msd_sub_unit u_sub (
    .a      (unit_a),
    .b      (unit_b),
    .result (unit_res)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        state_next = lst ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mean_value <= '0;
      divisor    <= msd_pkg::DIVISOR_W'(1);
      sum        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          msd_pkg::REG_MEAN_VALUE: mean_value <= cfg_data;
          msd_pkg::REG_DIVISOR:    divisor    <= cfg_data[msd_pkg::DIVISOR_W-1:0];
          default: ;
        endcase
      end

      if (state == ST_ACC) begin
        // A last item hands the total to the divider and starts a new set.
        sum <= lst ? '0 : sum_next;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp <= in_data.sample;
      inc <= in_data.include_req;
      lst <= in_data.last;
    end

    if (state == ST_MUL) begin
      square <= inc ? (msd_pkg::SQUARE_W'(abs_diff) * msd_pkg::SQUARE_W'(abs_diff)) : '0;
    end

    unique case (state)
      ST_ACC: begin
        work <= sum_next;
        rem  <= '0;
        cnt  <= DIV_LAST_STEP;
      end
      ST_DIV: begin
        work <= {work[msd_pkg::SUM_W-2:0], unit_res.ge};
        if (cnt == '0) begin
          // The quotient is complete; keep it and start the root on it.
          var_q <= {work[msd_pkg::SUM_W-2:0], unit_res.ge};
          rem   <= '0;
          root  <= '0;
          cnt   <= SQRT_LAST_STEP;
        end else begin
          rem <= unit_res.ge ? unit_res.diff : msd_pkg::UNIT_W'(div_shift);
          cnt <= cnt - 1'b1;
        end
      end
      ST_SQRT: begin
        rem  <= unit_res.ge ? unit_res.diff : sqrt_shift;
        root <= {root[msd_pkg::ROOT_W-2:0], unit_res.ge};
        work <= {work[msd_pkg::SUM_W-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase

    if (out_load) begin
      out_data.variance <= var_q;
      out_data.std_dev  <= root;
    end
  end

`ifndef NO_ASSERTIONS
  // A last item must clear the accumulator as the division starts.
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && lst) |=> (state == ST_DIV && sum == '0))
    else $error("accumulator not cleared at the end of a set");

  // The division hands over to the square root after its final step.
  a_div_to_sqrt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == '0) |=> (state == ST_SQRT && cnt == SQRT_LAST_STEP))
    else $error("division did not hand over to the square root");

  // A finished result always shows up at the output.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule

// ===== bench/tb_masked_standard_deviation.sv =====
// ----------------------------------------------------------------------------
// tb_masked_standard_deviation: self-checking bench for the standard deviation
// A directed table and then random sets of samples feed the block through its
// valid/stall input. Each accepted item goes through a local fixed-point
// predictor. Every result is compared with the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_masked_standard_deviation;
  timeunit 1ns;
  timeprecision 1ps;

  // The directed table and the saturation set bring the total to about 1600.
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 3000000;
  // One set long enough to drive the sum of squares into saturation. Each
  // item adds (2^24-1)^2, so just over 1024 of them are needed.
  localparam int SATURATE_LEN = 1030;
  localparam logic [msd_pkg::SUM_W-1:0]  SUM_ALL_ONES  = {msd_pkg::SUM_W{1'b1}};
  localparam logic [msd_pkg::ROOT_W-1:0] ROOT_ALL_ONES = {msd_pkg::ROOT_W{1'b1}};

  // What the bench expects for one item. A row with known_result set carries
  // a result read straight off the spec; otherwise the predictor decides.
  typedef struct packed {
    logic               known_result;
    msd_pkg::out_item_t stats;
  } item_check_t;

  // One row of the directed table. Register writes happen before the item,
  // once the block has drained.
  typedef struct packed {
    logic                          set_mean;
    logic [msd_pkg::MEAN_W-1:0]    mean;
    logic                          set_div;
    logic [msd_pkg::DIVISOR_W-1:0] div;
    msd_pkg::in_item_t             item;
    logic                          known_result;
    msd_pkg::out_item_t            stats;
  } directed_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [msd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [msd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  msd_pkg::in_item_t               in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  msd_pkg::out_item_t              out_data;

  // Travels alongside in_data so that the checker sees the check that
  // belongs to the item accepted at the same edge.
  item_check_t item_check = '0;

  // Bench-side copy of the block's registers and accumulator.
  logic [msd_pkg::MEAN_W-1:0]    model_mean    = '0;
  logic [msd_pkg::DIVISOR_W-1:0] model_divisor = 11'd1;
  logic [msd_pkg::SUM_W-1:0]     model_sum_sq  = '0;

  msd_pkg::out_item_t expected_stats_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int stall_run   = 0;

  masked_standard_deviation u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Truncated square root, settled one root bit at a time from the top.
  function automatic logic [msd_pkg::ROOT_W-1:0] floor_sqrt(logic [msd_pkg::SUM_W-1:0] v);
    logic [msd_pkg::ROOT_W-1:0] root;
    logic [msd_pkg::ROOT_W-1:0] trial;
    root = '0;
    for (int b = msd_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (msd_pkg::ROOT_W'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Folds one accepted sample into the accumulator. On a last item it forms
  // the variance and deviation, clears the accumulator and returns 1.
  function automatic logic step_stats(msd_pkg::in_item_t it,
                                      output msd_pkg::out_item_t stats);
    logic [msd_pkg::MEAN_W-1:0]   scaled;
    logic [msd_pkg::MEAN_W-1:0]   distance;
    logic [msd_pkg::SQUARE_W-1:0] square;
    logic [msd_pkg::SUM_W:0]      total;
    logic [msd_pkg::SUM_W-1:0]    var_q;
    stats = '0;
    if (it.include_req) begin
      scaled   = msd_pkg::MEAN_W'(it.sample) << msd_pkg::FRACTION_BITS;
      // The mean may sit above the scaled sample, so take the distance.
      distance = (scaled >= model_mean) ? scaled - model_mean : model_mean - scaled;
      square   = msd_pkg::SQUARE_W'(distance) * msd_pkg::SQUARE_W'(distance);
      total    = (msd_pkg::SUM_W + 1)'(model_sum_sq) + (msd_pkg::SUM_W + 1)'(square);
      // Saturate instead of wrapping once the sum passes 58 bits.
      model_sum_sq = total[msd_pkg::SUM_W] ? SUM_ALL_ONES : total[msd_pkg::SUM_W-1:0];
    end
    if (!it.last) begin
      return 1'b0;
    end
    // A zero divisor reads as an all-ones variance.
    var_q = (model_divisor == '0) ? SUM_ALL_ONES
                                  : model_sum_sq / msd_pkg::SUM_W'(model_divisor);
    stats.variance = var_q;
    stats.std_dev  = floor_sqrt(var_q);
    model_sum_sq   = '0;
    return 1'b1;
  endfunction

  // Scoreboard. Results are retired before new expectations are queued, since
  // a result can never belong to an item accepted at the same edge.
  always @(posedge clk) begin : scoreboard
    msd_pkg::out_item_t want;
    msd_pkg::out_item_t predicted;
    item_check_t        check;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_stats_q.size() == 0) begin
          $error("unexpected result: variance %0d, std_dev %0d",
                 out_data.variance, out_data.std_dev);
          error_count++;
        end else begin
          want = expected_stats_q.pop_front();
          if (out_data.variance !== want.variance) begin
            $error("variance mismatch: expected %0d, actual %0d",
                   want.variance, out_data.variance);
            error_count++;
          end
          if (out_data.std_dev !== want.std_dev) begin
            $error("std_dev mismatch: expected %0d, actual %0d",
                   want.std_dev, out_data.std_dev);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        check = item_check;
        if (step_stats(in_data, predicted)) begin
          expected_stats_q.push_back(check.known_result ? check.stats : predicted);
        end
      end
    end
  end

  // Output back-pressure: runs of stall and no stall, mostly short with the
  // occasional long hold. stall_pct of zero gives a stretch with no stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= ($urandom_range(9) == 0) ? $urandom_range(120, 30) : $urandom_range(3, 0);
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(4, 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offers one item, possibly after a random gap, and returns at the edge at
  // which it is accepted. Valid stays high afterwards so back-to-back items
  // need no extra step; the next gap or drain lowers it.
  task automatic send_item(msd_pkg::in_item_t item, logic known_result,
                           msd_pkg::out_item_t stats);
    int gap;
    gap = 0;
    if ($urandom_range(99) < gap_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= item;
    item_check <= '{known_result, stats};
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the input off until every pending result has come out, then lets
  // a few more cycles pass so the block is truly idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_stats_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes either or both registers on consecutive edges. The enable stays
  // high across back-to-back writes and drops once at the end.
  task automatic write_regs(logic do_mean, logic [msd_pkg::MEAN_W-1:0] mean,
                            logic do_div, logic [msd_pkg::CFG_DATA_W-1:0] div_word);
    if (do_mean) begin
      cfg_write <= 1'b1;
      cfg_index <= msd_pkg::REG_MEAN_VALUE;
      cfg_data  <= msd_pkg::CFG_DATA_W'(mean);
      @(posedge clk);
      model_mean = mean;
    end
    if (do_div) begin
      cfg_write <= 1'b1;
      cfg_index <= msd_pkg::REG_DIVISOR;
      cfg_data  <= div_word;
      @(posedge clk);
      // Bits above the divisor width are ignored by the block.
      model_divisor = div_word[msd_pkg::DIVISOR_W-1:0];
    end
    cfg_write <= 1'b0;
  endtask

  directed_row_t directed_rows [18];

  initial begin : stimulus
    msd_pkg::in_item_t              item;
    logic [msd_pkg::MEAN_W-1:0]     new_mean;
    logic [msd_pkg::DIVISOR_W-1:0]  new_div;
    logic [msd_pkg::CFG_DATA_W-1:0] div_word;
    int                             random_items;
    int                             phase_left;
    int                             set_len;
    int                             incl_pct;
    int                             pick;
    int                             near;

    // Directed table. Rows with a typed result are the obvious ones: a zero
    // sample at zero mean, one sample LSB of distance, an excluded last item on an
    // empty set, and a zero divisor which pins both outputs at all ones.
    directed_rows = '{
      // Straight out of reset: mean 0, divisor 1.
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd0, 1'b1, 1'b1}, 1'b1, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd1, 1'b1, 1'b1}, 1'b1, '{58'd65536, 29'd256}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'hFFFF, 1'b1, 1'b1}, 1'b0, '{58'd0, 29'd0}},
      // Excluded last item: result still comes out, from an empty sum.
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'hFFFF, 1'b0, 1'b1}, 1'b1, '{58'd0, 29'd0}},
      // Three-item set with the middle one masked off.
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd100, 1'b1, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd200, 1'b0, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd300, 1'b1, 1'b1}, 1'b0, '{58'd0, 29'd0}},
      // Largest mean: the mean lies above every scaled sample.
      '{1'b1, 24'hFFFFFF, 1'b1, 11'd1, '{16'd0, 1'b1, 1'b1}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'hFFFF, 1'b1, 1'b1}, 1'b0, '{58'd0, 29'd0}},
      // Zero divisor, with and without a sample counted.
      '{1'b0, 24'd0, 1'b1, 11'd0, '{16'd5, 1'b1, 1'b1}, 1'b1, '{SUM_ALL_ONES, ROOT_ALL_ONES}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd0, 1'b0, 1'b1}, 1'b1, '{SUM_ALL_ONES, ROOT_ALL_ONES}},
      // Largest divisor the register holds, well above the sample limit.
      '{1'b1, 24'd0, 1'b1, 11'h7FF, '{16'hFFFF, 1'b1, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'hFFFF, 1'b1, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd1, 1'b1, 1'b1}, 1'b0, '{58'd0, 29'd0}},
      // Mid-range mean with a fraction part and the nominal maximum divisor.
      '{1'b1, 24'h7FFF80, 1'b1, 11'd1024, '{16'd40000, 1'b1, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd12, 1'b1, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'd0, 1'b0, 1'b0}, 1'b0, '{58'd0, 29'd0}},
      '{1'b0, 24'd0, 1'b0, 11'd0, '{16'hFFFF, 1'b1, 1'b1}, 1'b0, '{58'd0, 29'd0}}
    };

    // Hold the synchronous reset, then release it.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with light idling on both sides.
    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_mean || directed_rows[r].set_div) begin
        wait_idle();
        write_regs(directed_rows[r].set_mean, directed_rows[r].mean,
                   directed_rows[r].set_div,
                   msd_pkg::CFG_DATA_W'(directed_rows[r].div));
      end
      send_item(directed_rows[r].item, directed_rows[r].known_result,
                directed_rows[r].stats);
    end

    // Accumulator saturation: the widest possible distance, summed over a set
    // longer than the sum can hold. The sender runs flat out here.
    wait_idle();
    gap_pct   = 0;
    stall_pct = 30;
    write_regs(1'b1, 24'hFFFFFF, 1'b1, msd_pkg::CFG_DATA_W'(11'd1));
    for (int k = 0; k < SATURATE_LEN; k++) begin
      item.sample      = '0;
      item.include_req = 1'b1;
      item.last        = (k == SATURATE_LEN - 1);
      send_item(item, 1'b0, '0);
    end

    // Random part: phases of complete sets, each phase under its own register
    // settings and idling levels. Every phase boundary drains the block, so
    // the sender regularly waits until nothing is outstanding.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(3) == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(50, 10);
        stall_pct = $urandom_range(60, 10);
      end

      pick = $urandom_range(9);
      if (pick < 2) begin
        new_mean = '0;
      end else if (pick == 2) begin
        new_mean = '1;
      end else if (pick < 5) begin
        new_mean = {16'($urandom), {msd_pkg::FRACTION_BITS{1'b0}}};
      end else begin
        new_mean = msd_pkg::MEAN_W'($urandom);
      end

      // Small divisors are favored so that they are near the set lengths.
      pick = $urandom_range(19);
      if (pick == 0) begin
        new_div = '0;
      end else if (pick == 1) begin
        new_div = 11'd1;
      end else if (pick == 2) begin
        new_div = '1;
      end else if (pick == 3) begin
        new_div = 11'd1024;
      end else if (pick < 14) begin
        new_div = msd_pkg::DIVISOR_W'($urandom_range(16, 1));
      end else begin
        new_div = msd_pkg::DIVISOR_W'($urandom_range(1024, 1));
      end
      div_word = msd_pkg::CFG_DATA_W'(new_div);
      // Junk in the unused upper bits of a divisor write must be ignored.
      if ($urandom_range(3) == 0) begin
        div_word[msd_pkg::CFG_DATA_W-1:msd_pkg::DIVISOR_W] =
          (msd_pkg::CFG_DATA_W - msd_pkg::DIVISOR_W)'($urandom);
      end
      write_regs($urandom_range(3) != 0, new_mean, $urandom_range(2) != 0, div_word);

      phase_left = $urandom_range(160, 40);
      while (phase_left > 0) begin
        set_len  = ($urandom_range(9) == 0) ? $urandom_range(80, 17) : $urandom_range(16, 1);
        // Most sets count nearly every sample; some are mostly masked.
        incl_pct = ($urandom_range(4) == 0) ? 30 : 85;
        for (int k = 0; k < set_len; k++) begin
          pick = $urandom_range(19);
          if (pick == 0) begin
            item.sample = '0;
          end else if (pick == 1) begin
            item.sample = '1;
          end else if (pick < 10) begin
            // Close to the mean, so small variances and roots show up too.
            near = int'(model_mean >> msd_pkg::FRACTION_BITS) +
                   int'($urandom_range(40)) - 20;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            item.sample = msd_pkg::SAMPLE_W'(near);
          end else begin
            item.sample = msd_pkg::SAMPLE_W'($urandom);
          end
          item.include_req = ($urandom_range(99) < incl_pct);
          item.last        = (k == set_len - 1);
          send_item(item, 1'b0, '0);
        end
        random_items += set_len;
        phase_left   -= set_len;
      end
    end

    // Drain, then allow a little more than one full result time.
    wait_idle();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/msd_pkg.sv
sv/msd_sub_unit.sv
sv/masked_standard_deviation.sv
bench/tb_masked_standard_deviation.sv
